/* hw/rtl/physical_frame_allocator_top_assert.svh */
// Assertion macros for the frame allocator checker.
`ifndef PHYSICAL_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define PHYSICAL_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Checked only out of reset.
`define PFA_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  prop) else $error("frame allocator check failed");

// Checked at every edge, reset included.
`define PFA_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("frame allocator reset check failed");

`endif

/* hw/rtl/pfa_pkg.sv */
// Shared types and constants of the physical frame allocator.
package pfa_pkg;

  localparam int FRAME_COUNT = 4096;
  localparam int FRAME_W     = 12;
  localparam int COUNT_W     = 13;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_SEED  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FS_UNUSABLE  = 2'd0,
    FS_FREE      = 2'd1,
    FS_ALLOCATED = 2'd2,
    FS_RESERVED  = 2'd3
  } frame_state_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EXHAUSTED = 2'd1,
    STS_BAD_FREE  = 2'd2,
    STS_SEED_REJ  = 2'd3
  } status_t;

endpackage

/* hw/rtl/pfa_if.sv */
// Valid/ready channel interfaces for request and response transfers.
interface pfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] frame_number;

  modport source (output valid, output kind, output frame_number, input ready);
  modport sink (input valid, input kind, input frame_number, output ready);
endinterface

interface pfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] result_frame;
  logic [1:0]  status;
  logic [12:0] free_count;

  modport source (output valid, output result_frame, output status, output free_count,
                  input ready);
  modport sink (input valid, input result_frame, input status, input free_count,
                output ready);
endinterface

/* hw/rtl/pfa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pfa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/physical_frame_allocator_top.sv */
// Physical frame allocator: a per-frame state map and a stack of free frame numbers, both
// held in synchronous RAMs. After reset the map is swept to unusable, one entry per cycle;
// in_ch.ready stays low during the sweep while cfg writes are still taken. Each transfer
// then reads the map (free, seed) or the stack top (allocate) as the request is taken and
// writes back and loads the response register once it is free. The response register lets
// the next request be taken while a response waits; the block holds one request in flight.
module physical_frame_allocator_top
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  pfa_req_if.sink            in_ch,
  pfa_rsp_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [FRAME_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [COUNT_W-1:0]   kres_r;
  logic [COUNT_W-1:0]   depth_r, depth_nxt;
  kind_t                kind_r;
  logic [FRAME_W-1:0]   frame_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 in_xfer;
  logic                 out_free;

  logic                 map_we, map_re;
  logic [FRAME_W-1:0]   map_waddr;
  logic [1:0]           map_wdata;
  logic [1:0]           map_rdata;
  logic                 stk_we, stk_re;
  logic [FRAME_W-1:0]   stk_raddr;
  logic [FRAME_W-1:0]   stk_rdata;

  logic                 in_range;
  logic                 below_res;
  logic                 not_full;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign in_range  = {1'b0, frame_r} < COUNT_W'(FRAME_COUNT);
  assign below_res = {1'b0, frame_r} < kres_r;
  assign not_full  = depth_r < COUNT_W'(FRAME_COUNT);

  // request-side reads
  assign map_re    = in_xfer;
  assign stk_re    = in_xfer && (kind_t'(in_ch.kind) == KIND_ALLOC);
  assign stk_raddr = FRAME_W'(depth_r - COUNT_W'(1));

  pfa_ram #(
    .DEPTH (FRAME_COUNT),
    .WIDTH (2)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (in_ch.frame_number),
    .rdata (map_rdata)
  );

  pfa_ram #(
    .DEPTH (FRAME_COUNT),
    .WIDTH (FRAME_W)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[FRAME_W-1:0]),
    .wdata (frame_r),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    depth_nxt      = depth_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_frame_nxt  = out_frame_r;
    out_status_nxt = out_status_r;
    map_we         = 1'b0;
    map_waddr      = frame_r;
    map_wdata      = FS_UNUSABLE;
    stk_we         = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        map_we      = 1'b1;
        map_waddr   = clr_cnt_r;
        map_wdata   = FS_UNUSABLE;
        clr_cnt_nxt = clr_cnt_r + FRAME_W'(1);
        if (clr_cnt_r == FRAME_W'(FRAME_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_frame_nxt  = '0;
          out_status_nxt = STS_OK;
          case (kind_r)
            KIND_ALLOC: begin
              if (depth_r == '0) begin
                out_status_nxt = STS_EXHAUSTED;
              end else begin
                depth_nxt     = depth_r - COUNT_W'(1);
                map_we        = 1'b1;
                map_waddr     = stk_rdata;
                map_wdata     = FS_ALLOCATED;
                out_frame_nxt = stk_rdata;
              end
            end
            KIND_FREE: begin
              if (in_range && frame_state_t'(map_rdata) == FS_ALLOCATED && not_full) begin
                map_we    = 1'b1;
                map_wdata = FS_FREE;
                stk_we    = 1'b1;
                depth_nxt = depth_r + COUNT_W'(1);
              end else begin
                out_status_nxt = STS_BAD_FREE;
              end
            end
            KIND_SEED: begin
              if (!in_range || frame_state_t'(map_rdata) != FS_UNUSABLE) begin
                out_status_nxt = STS_SEED_REJ;
              end else if (below_res) begin
                map_we    = 1'b1;
                map_wdata = FS_RESERVED;
              end else begin
                map_we    = 1'b1;
                map_wdata = FS_FREE;
                if (not_full) begin
                  stk_we    = 1'b1;
                  depth_nxt = depth_r + COUNT_W'(1);
                end
              end
            end
            default: begin
              out_status_nxt = STS_SEED_REJ;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      depth_r     <= '0;
      kres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        kres_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r  <= kind_t'(in_ch.kind);
      frame_r <= in_ch.frame_number;
    end
    if (state_r == S_EXEC && out_free) begin
      out_frame_r  <= out_frame_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= depth_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_frame = out_frame_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.free_count   = out_count_r;

endmodule

/* hw/rtl/pfa_chk.sv */
// Port-level checker for the frame allocator, bound to the top level.
`include "physical_frame_allocator_top_assert.svh"

module pfa_chk
  import pfa_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAME_W-1:0] out_result_frame,
  input logic [1:0]         out_status,
  input logic [COUNT_W-1:0] out_free_count
);

  `PFA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_ready)

  `PFA_ASSERT(a_count_bound, out_valid |-> out_free_count <= COUNT_W'(FRAME_COUNT))

  `PFA_ASSERT(a_exhausted_empty, out_valid && status_t'(out_status) == STS_EXHAUSTED |-> out_free_count == '0)

  `PFA_ASSERT(a_frame_only_ok, out_valid && status_t'(out_status) != STS_OK |-> out_result_frame == '0)

  `PFA_ASSERT(a_rsp_hold, out_valid && !out_ready |=> out_valid && $stable(out_result_frame) && $stable(out_status) && $stable(out_free_count))

endmodule

bind physical_frame_allocator_top pfa_chk u_pfa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_frame (out_ch.result_frame),
  .out_status       (out_ch.status),
  .out_free_count   (out_ch.free_count)
);

/* tb/physical_frame_allocator_top_tb.sv */
// Self-checking testbench for the physical frame allocator: random and directed transfers.
`timescale 1ns / 1ps

module physical_frame_allocator_top_tb;
  import pfa_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic [FRAME_W-1:0] frame;
  } frame_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } frame_rsp_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  pfa_req_if req_ch ();
  pfa_rsp_if rsp_ch ();

  physical_frame_allocator_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  frame_state_t       frame_map   [FRAME_COUNT];
  logic [FRAME_W-1:0] free_stack  [FRAME_COUNT];
  logic [COUNT_W-1:0] free_depth;
  logic [COUNT_W-1:0] reserved_frames;

  frame_req_t         pending_reqs[$];
  frame_rsp_t         predicted_rsps[$];
  logic [FRAME_W-1:0] seeded_frames[$];

  int  n_accepted;
  int  n_rsps;
  int  n_errors;
  int  n_cfg_writes;
  int  status_seen [4];
  logic hold_rsp;
  logic quiet;

  assign quiet = (n_accepted >= 400) && (n_accepted < 600);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic frame_rsp_t apply_frame_op(input frame_req_t req);
    frame_rsp_t r;
    r.frame  = '0;
    r.status = STS_SEED_REJ;
    case (req.kind)
      KIND_ALLOC: begin
        if (free_depth == 0) begin
          r.status = STS_EXHAUSTED;
        end else begin
          free_depth = free_depth - 1'b1;
          r.frame = free_stack[free_depth];
          frame_map[r.frame] = FS_ALLOCATED;
          r.status = STS_OK;
        end
      end
      KIND_FREE: begin
        if (frame_map[req.frame] == FS_ALLOCATED && free_depth < FRAME_COUNT) begin
          frame_map[req.frame] = FS_FREE;
          free_stack[free_depth] = req.frame;
          free_depth = free_depth + 1'b1;
          r.status = STS_OK;
        end else begin
          r.status = STS_BAD_FREE;
        end
      end
      KIND_SEED: begin
        if (frame_map[req.frame] != FS_UNUSABLE) begin
          r.status = STS_SEED_REJ;
        end else if ({1'b0, req.frame} < reserved_frames) begin
          frame_map[req.frame] = FS_RESERVED;
          r.status = STS_OK;
        end else begin
          frame_map[req.frame] = FS_FREE;
          if (free_depth < FRAME_COUNT) begin
            free_stack[free_depth] = req.frame;
            free_depth = free_depth + 1'b1;
          end
          r.status = STS_OK;
        end
      end
      default: r.status = STS_SEED_REJ;
    endcase
    r.count = free_depth;
    return r;
  endfunction

  function automatic void queue_req(input kind_t kind, input logic [FRAME_W-1:0] frame);
    frame_req_t r;
    r.kind  = kind;
    r.frame = frame;
    pending_reqs.push_back(r);
    if (kind == KIND_SEED) seeded_frames.push_back(frame);
  endfunction

  function automatic void queue_random_reqs(input int count);
    int roll;
    logic [FRAME_W-1:0] f;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      f = FRAME_W'($urandom);
      if (roll < 35) begin
        if (seeded_frames.size() != 0 && $urandom_range(9) == 0)
          f = seeded_frames[$urandom_range(seeded_frames.size() - 1)];
        queue_req(KIND_SEED, f);
      end else if (roll < 65) begin
        queue_req(KIND_ALLOC, f);
      end else if (roll < 95) begin
        if (seeded_frames.size() != 0 && $urandom_range(9) < 8)
          f = seeded_frames[$urandom_range(seeded_frames.size() - 1)];
        queue_req(KIND_FREE, f);
      end else begin
        queue_req(KIND_NONE, f);
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || predicted_rsps.size() != 0 || req_ch.valid);
  endtask

  task automatic write_reservation(input logic [COUNT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reserved_frames = value;
    n_cfg_writes++;
    @(negedge clk);
  endtask

  // Request driver: predicts on each transfer, then offers the next pending item.
  always @(posedge clk) begin : drive_reqs
    frame_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        nxt.kind  = kind_t'(req_ch.kind);
        nxt.frame = req_ch.frame_number;
        predicted_rsps.push_back(apply_frame_op(nxt));
        n_accepted <= n_accepted + 1;
      end
      if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 23)) begin
        nxt = pending_reqs.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= nxt.kind;
        req_ch.frame_number <= nxt.frame;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response monitor.
  always @(posedge clk) begin : check_rsps
    frame_rsp_t exp_rsp;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_rsps++;
        status_seen[rsp_ch.status]++;
        if (predicted_rsps.size() == 0) begin
          $error("response transfer with no expected response: frame %0d status %0d count %0d",
                 rsp_ch.result_frame, rsp_ch.status, rsp_ch.free_count);
          n_errors++;
        end else begin
          exp_rsp = predicted_rsps.pop_front();
          if (rsp_ch.result_frame !== exp_rsp.frame) begin
            $error("result_frame: expected %0d, actual %0d", exp_rsp.frame, rsp_ch.result_frame);
            n_errors++;
          end
          if (rsp_ch.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_ch.status);
            n_errors++;
          end
          if (rsp_ch.free_count !== exp_rsp.count) begin
            $error("free_count: expected %0d, actual %0d", exp_rsp.count, rsp_ch.free_count);
            n_errors++;
          end
        end
      end
      rsp_ch.ready <= !hold_rsp && (quiet || $urandom_range(99) >= 23);
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  initial begin
    hold_rsp = 1'b0;
    wait (n_accepted >= 700);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [COUNT_W-1:0] phase_cfg [5];
    foreach (frame_map[i]) frame_map[i] = FS_UNUSABLE;
    foreach (free_stack[i]) free_stack[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    free_depth          = '0;
    reserved_frames     = '0;
    n_accepted          = 0;
    n_rsps              = 0;
    n_errors            = 0;
    n_cfg_writes        = 0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_ALLOC;
    req_ch.frame_number = '0;
    rsp_ch.ready        = 1'b0;

    phase_cfg[0] = 13'd1200;
    phase_cfg[1] = 13'd0;
    phase_cfg[2] = 13'd4096;
    phase_cfg[3] = 13'd1;
    phase_cfg[4] = COUNT_W'($urandom_range(4096));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_reservation(13'd0);
    queue_req(KIND_ALLOC, 12'hFFF);
    queue_req(KIND_FREE, 12'h000);
    queue_req(KIND_NONE, 12'hFFF);
    queue_req(KIND_SEED, 12'h000);
    queue_req(KIND_SEED, 12'hFFF);
    queue_req(KIND_SEED, 12'h000);
    queue_req(KIND_ALLOC, 12'h000);
    queue_req(KIND_ALLOC, 12'hFFF);
    queue_req(KIND_ALLOC, 12'h000);
    queue_req(KIND_FREE, 12'hFFF);
    queue_req(KIND_FREE, 12'hFFF);
    queue_req(KIND_FREE, 12'h000);
    queue_req(KIND_SEED, 12'hAAA);
    queue_req(KIND_SEED, 12'h555);
    queue_req(KIND_ALLOC, 12'hAAA);
    queue_req(KIND_NONE, 12'h000);
    wait_drained();

    // Full reservation: every new seed is kept back, earlier free frames stay allocatable.
    write_reservation(13'd4096);
    queue_req(KIND_SEED, 12'h001);
    queue_req(KIND_SEED, 12'hFFE);
    queue_req(KIND_FREE, 12'h001);
    queue_req(KIND_SEED, 12'h001);
    queue_req(KIND_ALLOC, 12'h555);
    queue_req(KIND_FREE, 12'h555);
    wait_drained();

    foreach (phase_cfg[p]) begin
      write_reservation(phase_cfg[p]);
      queue_random_reqs(220);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (predicted_rsps.size() != 0) begin
      $error("%0d expected responses never arrived", predicted_rsps.size());
      n_errors++;
    end
    $display("Run covered %0d requests over %0d reservation settings (0 through 4096).",
             n_accepted, n_cfg_writes);
    $display("Responses: %0d ok, %0d exhausted, %0d ignored frees, %0d rejected seeds.",
             status_seen[STS_OK], status_seen[STS_EXHAUSTED], status_seen[STS_BAD_FREE],
             status_seen[STS_SEED_REJ]);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* physical_frame_allocator_top.f */
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_if.sv
hw/rtl/pfa_ram.sv
hw/rtl/physical_frame_allocator_top.sv
hw/rtl/pfa_chk.sv
tb/physical_frame_allocator_top_tb.sv
